/* hw/rtl/sufp_pkg.sv */
// ----------------------------------------------------------------------------
// sufp_pkg
// Types and constants shared by the slot update frame parser modules.
// ----------------------------------------------------------------------------
package sufp_pkg;

	// Frame parser phases, one-hot.
	typedef enum logic [5:0] {
		PH_HUNT = 6'b000001,
		PH_ID   = 6'b000010,
		PH_D0   = 6'b000100,
		PH_D1   = 6'b001000,
		PH_D2   = 6'b010000,
		PH_D3   = 6'b100000
	} phase_t;

	// Header byte value that opens a frame.
	localparam logic [7:0] HEADER_BYTE = 8'h00;

	// Reset value of the slot count register.
	localparam logic [7:0] SLOT_COUNT_RESET = 8'd16;

	// One received byte with its end-of-packet mark.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_packet;
	} rx_item_t;

	// One slot write.
	typedef struct packed {
		logic [7:0]  slot_index;
		logic [31:0] slot_value;
	} slot_write_t;

endpackage

/* hw/rtl/sufp_in_stage.sv */
// ----------------------------------------------------------------------------
// sufp_in_stage
// Input register: captures one received byte item and holds it while the
// downstream stage is blocked.
// ----------------------------------------------------------------------------
module sufp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sufp_pkg::rx_item_t in_item,
	input  logic               advance,
	output logic               valid_s1,
	output sufp_pkg::rx_item_t item_s1
);
	import sufp_pkg::*;

	// The register is free when empty or when its item moves on this cycle.
	assign in_stall = valid_s1 && !advance;

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* hw/rtl/sufp_frame_fsm.sv */
// ----------------------------------------------------------------------------
// sufp_frame_fsm
// Frame hunting state machine: consumes one byte item per step and produces
// at most one slot write.
// ----------------------------------------------------------------------------
module sufp_frame_fsm #(
	parameter int PACKET_MAX = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic                  step,
	input  sufp_pkg::rx_item_t    item,
	output logic                  res_valid,
	output sufp_pkg::slot_write_t res
);
	import sufp_pkg::*;

	localparam int CNT_W = $clog2(PACKET_MAX + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PACKET_MAX);

	logic [7:0]       slot_count_q;
	phase_t           phase_q, phase_d;
	logic [7:0]       pending_id_q, pending_id_d;
	logic [23:0]      data_q, data_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// Slot count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RESET;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	// Next state and result for the byte in hand.
	always_comb begin
		phase_d      = phase_q;
		pending_id_d = pending_id_q;
		data_d       = data_q;
		cnt_d        = cnt_q;
		res_valid    = 1'b0;
		res.slot_index = pending_id_q - 8'd1;
		res.slot_value = {item.rx_byte, data_q};
		if (cnt_q < CNT_MAX) begin
			cnt_d = cnt_q + CNT_W'(1);
			case (phase_q)
				PH_HUNT: begin
					if (item.rx_byte == HEADER_BYTE) begin
						phase_d = PH_ID;
					end
				end
				PH_ID: begin
					if (item.rx_byte <= slot_count_q) begin
						pending_id_d = item.rx_byte;
						data_d       = 24'd0;
						phase_d      = PH_D0;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_D0: begin
					data_d[7:0] = item.rx_byte;
					phase_d     = PH_D1;
				end
				PH_D1: begin
					data_d[15:8] = item.rx_byte;
					phase_d      = PH_D2;
				end
				PH_D2: begin
					data_d[23:16] = item.rx_byte;
					phase_d       = PH_D3;
				end
				PH_D3: begin
					// A frame with id zero is consumed without a write.
					res_valid    = (pending_id_q != 8'd0);
					phase_d      = PH_HUNT;
					pending_id_d = 8'd0;
					data_d       = 24'd0;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
		// Every end of packet drops an open frame and restarts the count.
		if (item.end_of_packet) begin
			phase_d      = PH_HUNT;
			pending_id_d = 8'd0;
			data_d       = 24'd0;
			cnt_d        = '0;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			pending_id_q <= 8'd0;
			data_q       <= 24'd0;
			cnt_q        <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			pending_id_q <= pending_id_d;
			data_q       <= data_d;
			cnt_q        <= cnt_d;
		end
	end

endmodule

/* hw/rtl/sufp_out_stage.sv */
// ----------------------------------------------------------------------------
// sufp_out_stage
// Result register: holds one slot write until the receiver takes it.
// ----------------------------------------------------------------------------
module sufp_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  res_valid,
	input  sufp_pkg::slot_write_t res,
	output logic                  advance,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            slot_index,
	output logic [31:0]           slot_value
);
	import sufp_pkg::*;

	slot_write_t res_q;

	// The register can be reloaded when empty or drained this cycle.
	assign advance = !(out_valid && out_stall);

	// Valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= step && res_valid;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (advance && step && res_valid) begin
			res_q <= res;
		end
	end

	assign slot_index = res_q.slot_index;
	assign slot_value = res_q.slot_value;

endmodule

/* hw/rtl/slot_update_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// slot_update_frame_parser_unit
// Top level of the slot update frame parser.
// ----------------------------------------------------------------------------
// The unit takes one packet byte per cycle while not stalled and issues slot
// writes for each complete six-byte frame (zero header, slot id, four data
// bytes least significant first) whose id lies in 1..slot_count. A byte is
// registered on entry, runs through the frame state machine while it is held
// in the input register, and its slot write, if any, is registered in the
// result register; the unit takes a new byte while the previous byte's write
// is still in the result register. Input stalls only when the result register
// is full and stalled. Write slot_count only while the unit is idle; only the
// first PACKET_MAX bytes of each packet are parsed.
// ----------------------------------------------------------------------------
module slot_update_frame_parser_unit #(
	parameter int PACKET_MAX = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_packet,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  slot_index,
	output logic [31:0] slot_value
);
	import sufp_pkg::*;

	rx_item_t    in_item;
	rx_item_t    item_s1;
	logic        valid_s1;
	logic        advance;
	logic        step;
	logic        res_valid;
	slot_write_t res;

	assign in_item.rx_byte       = rx_byte;
	assign in_item.end_of_packet = end_of_packet;

	// The registered byte is parsed when the result side can take its outcome.
	assign step = valid_s1 && advance;

	sufp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sufp_frame_fsm #(
		.PACKET_MAX (PACKET_MAX)
	) u_frame_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sufp_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.res_valid  (res_valid),
		.res        (res),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_index (slot_index),
		.slot_value (slot_value)
	);

endmodule
